[sv/ring_outlier_rejecting_average_core_assert.svh]
// Assertion macros for the ring outlier-rejecting average core.
// Included by the top level; no other dependencies.
`ifndef RING_OUTLIER_REJECTING_AVERAGE_CORE_ASSERT_SVH
`define RING_OUTLIER_REJECTING_AVERAGE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ROAR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ROAR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ROAR_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define ROAR_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

[sv/roar_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the ring outlier-rejecting average core.
// No dependencies.
package roar_pkg;

  localparam int RING_SAMPLES_DEF = 5;
  localparam int CM_DIVISOR       = 58;

  localparam int SAMPLE_W    = 15;
  localparam int SAMPLE_MAX  = 32767;
  localparam int RATIO_HI_W  = 5;
  localparam int RATIO_LO_W  = 4;
  localparam int RETRY_W     = 6;
  localparam int DIST_W      = 18;
  localparam int CFG_W       = 6;
  localparam int CFG_ADDR_W  = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  localparam logic [RETRY_W-1:0]    MAX_RETRIES_RST = 6'd30;
  localparam logic [RATIO_HI_W-1:0] HIGH_RATIO_RST  = 5'd14;
  localparam logic [RATIO_LO_W-1:0] LOW_RATIO_RST   = 4'd6;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MAX_RETRIES = 2'd0,
    CFG_HIGH_RATIO  = 2'd1,
    CFG_LOW_RATIO   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic shift;
    logic scan;
  } cell_ctrl_t;

endpackage

[sv/roar_cell.sv]
`timescale 1ns / 1ps
// One ring cell: holds a sample, shifts it on, and passes the outlier flag down the row.
// Depends on roar_pkg.
module roar_cell #(
  parameter int SCALE = 10 * roar_pkg::RING_SAMPLES_DEF,
  parameter int CMP_W = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  roar_pkg::cell_ctrl_t          ctrl,
  input  logic [roar_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                          flag_in,
  input  logic [CMP_W-1:0]              hi_bound,
  input  logic [CMP_W-1:0]              lo_bound,
  output logic [roar_pkg::SAMPLE_W-1:0] sample,
  output logic                          flag
);

  logic [CMP_W-1:0] scaled;
  logic             outlier;

  assign scaled  = CMP_W'(sample) * CMP_W'(SCALE);
  assign outlier = (scaled > hi_bound) || (scaled < lo_bound);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      sample <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.scan) begin
      flag <= flag_in | outlier;
    end
  end

endmodule

[sv/roar_q8_conv.sv]
`timescale 1ns / 1ps
// Ring sum to mean distance in cm, Q8: floor(sum*256/(N*58)) by reciprocal multiply.
// Depends on roar_pkg.
module roar_q8_conv #(
  parameter int RING_SAMPLES = roar_pkg::RING_SAMPLES_DEF,
  parameter int SUM_W        = 18
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic [SUM_W-1:0]            ring_sum,
  output logic [roar_pkg::DIST_W-1:0] distance_q8
);

  localparam int              DIVISOR = RING_SAMPLES * roar_pkg::CM_DIVISOR;
  localparam int              NUM_W   = SUM_W + 8;
  localparam int              SHIFT   = NUM_W + $clog2(DIVISOR);
  localparam longint unsigned POW     = 64'd1 << SHIFT;
  localparam longint unsigned RECIP   = (POW + DIVISOR - 1) / DIVISOR;
  localparam int              RECIP_W = $clog2(RECIP + 1);
  localparam int              PROD_W  = NUM_W + RECIP_W + roar_pkg::DIST_W;

  logic [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= PROD_W'({ring_sum, 8'd0}) * PROD_W'(RECIP_W'(RECIP));
    end
  end

  assign distance_q8 = prod[SHIFT +: roar_pkg::DIST_W];

endmodule

[sv/ring_outlier_rejecting_average_core.sv]
`timescale 1ns / 1ps
// Ring outlier-rejecting average of ultrasonic echo times, top level.
// Depends on roar_pkg, roar_cell, roar_q8_conv and the assertion macro header.
//
// Each beat on the input carries one echo time; a beat with tuser low counts as a zero
// sample. The first RING_SAMPLES beats fill a row of cells, one cycle each, with no
// result. The beat that completes the ring, and every replacement beat after it, starts
// an outlier test: the bounds are computed, then the outlier flag walks the cell row
// one cell per cycle, and the flag leaving the last cell decides the outcome; a result
// then waits for any drain of the output register. A result is the mean distance in cm
// as Q8, or a failure beat with distance zero once max_retries replacements (one when
// max_retries is zero) leave outliers in the ring; either one restarts the fill.
// Ratio writes take effect at the next test, a max_retries write at the next decision.
module ring_outlier_rejecting_average_core #(
  parameter int RING_SAMPLES = roar_pkg::RING_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [roar_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [14:0] echo_time
  input  logic [0:0]                        s_axis_tuser,  // [0] echo_seen
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [roar_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [17:0] distance_q8, [23:18] retries_used
  output logic [0:0]                        m_axis_tuser,  // [0] failed
  input  logic                              cfg_we,
  input  logic [roar_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [roar_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int FILL_W   = $clog2(RING_SAMPLES + 1);
  localparam int SCAN_W   = $clog2(RING_SAMPLES);
  localparam int SUM_W    = $clog2(RING_SAMPLES * roar_pkg::SAMPLE_MAX + 1);
  localparam int SCALE    = 10 * RING_SAMPLES;
  localparam int SCALED_W = roar_pkg::SAMPLE_W + $clog2(SCALE + 1);
  localparam int BOUND_W  = SUM_W + roar_pkg::RATIO_HI_W;
  localparam int CMP_W    = (SCALED_W > BOUND_W) ? SCALED_W : BOUND_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_BOUNDS = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                            state;
  logic [FILL_W-1:0]                 fill_count;
  logic [roar_pkg::RETRY_W-1:0]      retry_count;
  logic [SUM_W-1:0]                  ring_sum;
  logic [SCAN_W-1:0]                 scan_cnt;
  logic [CMP_W-1:0]                  hi_bound;
  logic [CMP_W-1:0]                  lo_bound;
  logic                              res_fail;
  logic [roar_pkg::RETRY_W-1:0]      max_retries;
  logic [roar_pkg::RATIO_HI_W-1:0]   high_ratio_tenths;
  logic [roar_pkg::RATIO_LO_W-1:0]   low_ratio_tenths;

  logic                              accept;
  logic                              ring_full;
  logic                              out_free;
  logic [roar_pkg::SAMPLE_W-1:0]     new_sample;
  logic [roar_pkg::SAMPLE_W-1:0]     tail;
  logic [roar_pkg::RETRY_W-1:0]      limit;
  logic [roar_pkg::DIST_W-1:0]       conv_dist;
  roar_pkg::cell_ctrl_t              cell_ctrl;

  logic [roar_pkg::SAMPLE_W-1:0]     samples [RING_SAMPLES];
  logic                              flags   [RING_SAMPLES];

  assign s_axis_tready   = (state == ST_IDLE);
  assign accept          = s_axis_tvalid && s_axis_tready;
  assign ring_full       = (fill_count == FILL_W'(RING_SAMPLES));
  assign out_free        = !m_axis_tvalid || m_axis_tready;
  assign new_sample      = s_axis_tuser[0] ? s_axis_tdata[roar_pkg::SAMPLE_W-1:0] : '0;
  assign tail            = samples[RING_SAMPLES-1];
  assign limit           = (max_retries == '0) ? roar_pkg::RETRY_W'(1) : max_retries;
  assign cell_ctrl.shift = accept;
  assign cell_ctrl.scan  = (state == ST_SCAN);

  for (genvar i = 0; i < RING_SAMPLES; i++) begin : g_cell
    logic [roar_pkg::SAMPLE_W-1:0] cell_in;
    logic                          cell_flag_in;
    if (i == 0) begin : g_head
      assign cell_in      = new_sample;
      assign cell_flag_in = 1'b0;
    end else begin : g_body
      assign cell_in      = samples[i-1];
      assign cell_flag_in = flags[i-1];
    end
    roar_cell #(
      .SCALE (SCALE),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .sample_in (cell_in),
      .flag_in   (cell_flag_in),
      .hi_bound  (hi_bound),
      .lo_bound  (lo_bound),
      .sample    (samples[i]),
      .flag      (flags[i])
    );
  end

  roar_q8_conv #(
    .RING_SAMPLES (RING_SAMPLES),
    .SUM_W        (SUM_W)
  ) u_conv (
    .clk         (clk),
    .load        (state == ST_DECIDE),
    .ring_sum    (ring_sum),
    .distance_q8 (conv_dist)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries       <= roar_pkg::MAX_RETRIES_RST;
      high_ratio_tenths <= roar_pkg::HIGH_RATIO_RST;
      low_ratio_tenths  <= roar_pkg::LOW_RATIO_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        roar_pkg::CFG_MAX_RETRIES: max_retries <= cfg_wdata;
        roar_pkg::CFG_HIGH_RATIO:  high_ratio_tenths <= cfg_wdata[roar_pkg::RATIO_HI_W-1:0];
        roar_pkg::CFG_LOW_RATIO:   low_ratio_tenths <= cfg_wdata[roar_pkg::RATIO_LO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_BOUNDS: begin
        hi_bound <= CMP_W'(high_ratio_tenths) * CMP_W'(ring_sum);
        lo_bound <= CMP_W'(low_ratio_tenths) * CMP_W'(ring_sum);
      end
      ST_EMIT: begin
        if (out_free) begin
          m_axis_tdata <= {retry_count, res_fail ? roar_pkg::DIST_W'(0) : conv_dist};
          m_axis_tuser <= res_fail;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_count    <= '0;
      retry_count   <= '0;
      ring_sum      <= '0;
      scan_cnt      <= '0;
      res_fail      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!ring_full) begin
              ring_sum   <= ring_sum + SUM_W'(new_sample);
              fill_count <= fill_count + FILL_W'(1);
              if (fill_count == FILL_W'(RING_SAMPLES - 1)) begin
                state <= ST_BOUNDS;
              end
            end else begin
              ring_sum    <= ring_sum - SUM_W'(tail) + SUM_W'(new_sample);
              retry_count <= retry_count + roar_pkg::RETRY_W'(1);
              state       <= ST_BOUNDS;
            end
          end
        end
        ST_BOUNDS: begin
          scan_cnt <= '0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_cnt == SCAN_W'(RING_SAMPLES - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!flags[RING_SAMPLES-1]) begin
            res_fail <= 1'b0;
            state    <= ST_EMIT;
          end else if (retry_count >= limit) begin
            res_fail <= 1'b1;
            state    <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            ring_sum      <= '0;
            fill_count    <= '0;
            retry_count   <= '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "ring_outlier_rejecting_average_core_assert.svh"

  `ROAR_ASSERT_IMP(a_fail_beat_zero, clk, rst, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[roar_pkg::DIST_W-1:0] == '0) && (m_axis_tdata[roar_pkg::OUT_TDATA_W-1:roar_pkg::DIST_W] != '0), "failure beat with nonzero distance or no retries")
  `ROAR_ASSERT_IMP(a_test_on_full_ring, clk, rst, (state == ST_SCAN) || (state == ST_DECIDE), ring_full, "outlier test on a ring that is not full")
  `ROAR_ASSERT_NXT(a_emit_restarts_fill, clk, rst, (state == ST_EMIT) && out_free, m_axis_tvalid && (fill_count == '0) && (ring_sum == '0) && (retry_count == '0), "result emitted without restarting the fill")
  `ROAR_ASSERT_IMP(a_fill_bounded, clk, rst, 1'b1, fill_count <= FILL_W'(RING_SAMPLES), "fill count past ring size")

endmodule

[bench/ring_outlier_rejecting_average_core_tb.sv]
`timescale 1ns / 1ps
// Testbench for ring_outlier_rejecting_average_core: directed and random echo streams,
// each result beat checked against an in-bench prediction of the ring average.
// Depends on roar_pkg and the core RTL.
module ring_outlier_rejecting_average_core_tb;

  localparam int RING = roar_pkg::RING_SAMPLES_DEF;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 4 * (RING + 4);
  localparam int DRAIN_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 150;
  localparam logic [roar_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {BURST_STEADY, BURST_SPIKY, BURST_NOISE} burst_kind_t;

  typedef struct packed {
    logic [roar_pkg::DIST_W-1:0]  distance_q8;
    logic                         failed;
    logic [roar_pkg::RETRY_W-1:0] retries_used;
  } distance_beat_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [roar_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]                       s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [roar_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]                       m_axis_tuser;
  logic                             cfg_we = 1'b0;
  logic [roar_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [roar_pkg::CFG_W-1:0]       cfg_wdata = '0;

  ring_outlier_rejecting_average_core #(
    .RING_SAMPLES(RING)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  int fail_count = 0;
  int cycle_count = 0;
  bit src_idle_on = 1'b1;
  bit sink_stall_on = 1'b1;
  int sink_hold_cycles = 0;

  int phase_max_retries [PHASES] = '{30, 1, 63, 0, 5, 20, 8, 63};
  int phase_high_ratio  [PHASES] = '{14, 10, 30, 31, 10, 12, 20, 10};
  int phase_low_ratio   [PHASES] = '{6, 0, 10, 15, 10, 63, 3, 0};

  logic [roar_pkg::SAMPLE_W-1:0]   ring_model [RING];
  int unsigned                     ring_total;
  int unsigned                     fill_level;
  int unsigned                     next_slot;
  logic [roar_pkg::RETRY_W-1:0]    retry_level;
  logic [roar_pkg::RETRY_W-1:0]    max_retries_reg;
  logic [roar_pkg::RATIO_HI_W-1:0] high_ratio_reg;
  logic [roar_pkg::RATIO_LO_W-1:0] low_ratio_reg;
  distance_beat_t                  expected_distances [$];

  function automatic void restart_fill();
    ring_total = 0;
    fill_level = 0;
    next_slot = 0;
    retry_level = '0;
  endfunction

  function automatic bit ring_has_outlier();
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned scaled;
    hi = ring_total;
    hi = hi * high_ratio_reg;
    lo = ring_total;
    lo = lo * low_ratio_reg;
    for (int i = 0; i < RING; i++) begin
      scaled = ring_model[i];
      scaled = scaled * (10 * RING);
      if (scaled > hi || scaled < lo) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_distance(input logic [roar_pkg::SAMPLE_W-1:0] echo_time,
                                           input logic echo_seen);
    logic [roar_pkg::SAMPLE_W-1:0] sample;
    longint unsigned               q8;
    int unsigned                   limit;
    sample = echo_seen ? echo_time : '0;
    if (fill_level < RING) begin
      ring_model[fill_level] = sample;
      ring_total += sample;
      fill_level++;
      if (fill_level < RING) return;
    end else begin
      ring_total = ring_total - ring_model[next_slot] + sample;
      ring_model[next_slot] = sample;
      next_slot = (next_slot + 1) % RING;
      retry_level = retry_level + 1'b1;
    end
    if (!ring_has_outlier()) begin
      q8 = (longint'(ring_total) * 256) / (RING * roar_pkg::CM_DIVISOR);
      expected_distances.push_back(
        distance_beat_t'{q8[roar_pkg::DIST_W-1:0], 1'b0, retry_level});
      restart_fill();
      return;
    end
    limit = (max_retries_reg == 0) ? 1 : max_retries_reg;
    if (retry_level >= limit) begin
      expected_distances.push_back(distance_beat_t'{'0, 1'b1, retry_level});
      restart_fill();
    end
  endfunction

  function automatic int stall_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Hold tvalid across back-to-back beats; lower it only ahead of a real gap.
  task automatic send_echo(input logic [roar_pkg::SAMPLE_W-1:0] echo_time,
                           input logic echo_seen);
    int gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 99) >= 45) gap = stall_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, echo_time};
    s_axis_tuser  <= echo_seen;
    do @(posedge clk); while (!s_axis_tready);
    predict_distance(echo_time, echo_seen);
  endtask

  task automatic wait_results_drained();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_distances.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_distances.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_distances.size());
      fail_count++;
      expected_distances.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [roar_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [roar_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      roar_pkg::CFG_MAX_RETRIES: max_retries_reg = val[roar_pkg::RETRY_W-1:0];
      roar_pkg::CFG_HIGH_RATIO:  high_ratio_reg  = val[roar_pkg::RATIO_HI_W-1:0];
      roar_pkg::CFG_LOW_RATIO:   low_ratio_reg   = val[roar_pkg::RATIO_LO_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int pick_base();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(500, 3000);
      3, 4, 5: return $urandom_range(3000, 30000);
      6:       return $urandom_range(0, 40);
      7:       return $urandom_range(30000, roar_pkg::SAMPLE_MAX);
      default: return $urandom_range(0, roar_pkg::SAMPLE_MAX);
    endcase
  endfunction

  task automatic gen_echo(input burst_kind_t kind, input int base,
                          output logic [roar_pkg::SAMPLE_W-1:0] echo_time,
                          output logic echo_seen);
    int v;
    v = base + $urandom_range(0, base >> $urandom_range(3, 16));
    echo_seen = 1'b1;
    if (kind == BURST_NOISE) begin
      v = $urandom_range(0, roar_pkg::SAMPLE_MAX);
      echo_seen = ($urandom_range(0, 9) != 0);
    end else if (kind == BURST_SPIKY && $urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = 0;
        1:       echo_seen = 1'b0;
        2:       v = base * 3;
        default: v = $urandom_range(0, roar_pkg::SAMPLE_MAX);
      endcase
    end
    if (v > roar_pkg::SAMPLE_MAX) v = roar_pkg::SAMPLE_MAX;
    echo_time = v[roar_pkg::SAMPLE_W-1:0];
  endtask

  task automatic test_zero_ring();
    send_echo(15'h7FFF, 1'b0);
    send_echo(15'd0, 1'b1);
    send_echo(15'd12345, 1'b0);
    send_echo(15'd0, 1'b1);
    send_echo(15'd1, 1'b0);
    wait_results_drained();
  endtask

  task automatic test_full_scale();
    repeat (RING) send_echo(15'h7FFF, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_retry_edges();
    write_reg(roar_pkg::CFG_MAX_RETRIES, 6'd1);
    send_echo(15'd5000, 1'b1);
    repeat (RING - 1) send_echo(15'd1000, 1'b1);
    send_echo(15'd1000, 1'b1);
    wait_results_drained();
    write_reg(roar_pkg::CFG_MAX_RETRIES, 6'd0);
    send_echo(15'd5000, 1'b1);
    repeat (RING - 1) send_echo(15'd1000, 1'b1);
    send_echo(15'd5000, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_odd_ratios();
    write_reg(roar_pkg::CFG_HIGH_RATIO, 6'd10);
    write_reg(roar_pkg::CFG_LOW_RATIO, 6'd15);
    write_reg(CFG_SPARE, 6'h3F);
    repeat (RING + 1) send_echo(15'd2000, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_backpressure();
    int base;
    logic [roar_pkg::SAMPLE_W-1:0] t;
    logic seen;
    base = $urandom_range(1000, 20000);
    src_idle_on = 1'b0;
    sink_hold_cycles = 300;
    repeat (40) begin
      gen_echo(BURST_STEADY, base, t, seen);
      send_echo(t, seen);
    end
    wait_results_drained();
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_phase(input int p);
    int sent;
    int len;
    int base;
    int r;
    burst_kind_t kind;
    logic [roar_pkg::SAMPLE_W-1:0] t;
    logic seen;
    write_reg(roar_pkg::CFG_MAX_RETRIES, roar_pkg::CFG_W'(phase_max_retries[p]));
    write_reg(roar_pkg::CFG_HIGH_RATIO, roar_pkg::CFG_W'(phase_high_ratio[p]));
    write_reg(roar_pkg::CFG_LOW_RATIO, roar_pkg::CFG_W'(phase_low_ratio[p]));
    src_idle_on   = (p != 3 && p != 6);
    sink_stall_on = (p != 3 && p != 5);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      kind = (r < 60) ? BURST_STEADY : (r < 85) ? BURST_SPIKY : BURST_NOISE;
      base = pick_base();
      len = $urandom_range(RING, 3 * RING);
      repeat (len) begin
        gen_echo(kind, base, t, seen);
        send_echo(t, seen);
      end
      sent += len;
    end
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL ring_outlier_rejecting_average_core");
      $finish;
    end
  end

  // Drive the result side: random stalls, plus a long hold on request.
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_stall_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_length()) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : distance_checker
    distance_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_distances.size() == 0) begin
        $error("result beat with nothing expected: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = expected_distances.pop_front();
        if (m_axis_tdata[roar_pkg::DIST_W-1:0] !== want.distance_q8) begin
          $error("distance_q8 expected %0d actual %0d", want.distance_q8,
                 m_axis_tdata[roar_pkg::DIST_W-1:0]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.failed) begin
          $error("failed expected %0d actual %0d", want.failed, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tdata[roar_pkg::DIST_W +: roar_pkg::RETRY_W] !== want.retries_used) begin
          $error("retries_used expected %0d actual %0d", want.retries_used,
                 m_axis_tdata[roar_pkg::DIST_W +: roar_pkg::RETRY_W]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < RING; i++) ring_model[i] = '0;
    max_retries_reg = roar_pkg::MAX_RETRIES_RST;
    high_ratio_reg  = roar_pkg::HIGH_RATIO_RST;
    low_ratio_reg   = roar_pkg::LOW_RATIO_RST;
    restart_fill();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_zero_ring();
    test_full_scale();
    test_retry_edges();
    test_odd_ratios();
    test_backpressure();
    for (int p = 0; p < PHASES; p++) test_random_phase(p);
    wait_results_drained();
    if (fail_count == 0) begin
      $display("PASS ring_outlier_rejecting_average_core");
    end else begin
      $display("FAIL ring_outlier_rejecting_average_core");
    end
    $finish;
  end

endmodule

[ring_outlier_rejecting_average_core.f]
+incdir+sv
sv/roar_pkg.sv
sv/roar_cell.sv
sv/roar_q8_conv.sv
sv/ring_outlier_rejecting_average_core.sv
bench/ring_outlier_rejecting_average_core_tb.sv
